// ----- rtl/pcg_pkg.sv -----
package pcg_pkg;

    localparam logic [63:0] PCG_MULT = 64'd6364136223846793005;
    localparam logic [63:0] RESET_STATE = 64'd6364136223846793006;

    typedef enum logic [2:0] {
        OP_NEXT32  = 3'd0,
        OP_NEXT64  = 3'd1,
        OP_UNIFORM = 3'd2,
        OP_SKIP    = 3'd3,
        OP_RESEED  = 3'd4
    } opcode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DRAW,
        ST_MOD,
        ST_SKIP_BIT,
        ST_SKIP_SQ,
        ST_SKIP_FIN,
        ST_RES_ADD,
        ST_OUT
    } state_t;

    function automatic logic [31:0] xsh_rr(input logic [63:0] old);
        logic [31:0] xs;
        logic [4:0]  rot;
        xs  = 32'(((old >> 18) ^ old) >> 27);
        rot = old[63:59];
        return (xs >> rot) | (xs << ((5'd0 - rot) & 5'd31));
    endfunction

endpackage

// ----- rtl/pcg_if.sv -----
interface pcg_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
    logic [63:0] skip_count;
    modport source (output valid, opcode, range_low, range_high, skip_count, input ready);
    modport sink   (input valid, opcode, range_low, range_high, skip_count, output ready);
endinterface

interface pcg_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] random_value;
    logic signed [31:0] uniform_value;
    modport source (output valid, random_value, uniform_value, input ready);
    modport sink   (input valid, random_value, uniform_value, output ready);
endinterface

// ----- rtl/pcg32_generator_with_jump.sv -----
// channel   dir  payload
// req       in   opcode, range_low, range_high, skip_count
// res       out  random_value, uniform_value
// cfg       in   cfg_we / cfg_wdata -> seed_reg
// one request at a time; ready only in idle with no result pending
// each draw is one 64-bit multiply on the shared unit, built from 3 partial products
// uniform with full span needs no remainder step, with equal bounds no draw
// skip: per count bit the accumulator is updated only if the bit is set, then multiplier and increment are squared
// reseed: step from zero, add the seed, step again, no result; reset: async, state loads the seed-zero values
// result held in the output register until taken
module pcg32_generator_with_jump
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [63:0]  cfg_wdata,
    pcg_req_if.sink      req,
    pcg_res_if.source    res
);
    import pcg_pkg::*;

    state_t state_reg, state_next;
    logic [63:0] seed_reg;
    logic [63:0] lcg_reg, inc_reg;
    opcode_t     op_reg;
    logic [1:0]  phase_reg;         // draw count / reseed progress
    logic [31:0] lo_reg, span_reg, r_reg, hi_reg;
    logic        full_reg;
    logic [63:0] n_reg, cm_reg, cp_reg, am_reg, ap_reg;
    logic [1:0]  sub_reg;           // skip sub-step
    logic        mod_go_reg;        // remainder unit kicked once the draw is latched

    // shared multiplier
    logic        mstart;
    logic [63:0] ma, mb, mp;
    logic        mdone;
    pcg_mul64 u_mul (.clk, .rst_n, .start(mstart), .a(ma), .b(mb), .done(mdone), .p(mp));

    logic        ddone;
    logic [31:0] drem;
    pcg_divmod u_div (.clk, .rst_n, .start(mod_go_reg), .num(r_reg), .den(span_reg),
                      .done(ddone), .rem(drem));

    logic        mbusy_reg;
    logic signed [31:0] a_s, b_s, mn, mx;

    always_comb
    begin
        a_s = req.range_low;
        b_s = req.range_high;
        mn = (a_s > b_s) ? b_s : a_s;
        mx = (a_s > b_s) ? a_s : b_s;
    end

    assign req.ready = (state_reg == ST_IDLE) && !res.valid;

    // multiplier operands by state
    always_comb
    begin
        ma = lcg_reg;
        mb = PCG_MULT;
        unique case (state_reg)
            ST_SKIP_BIT: begin ma = (sub_reg == 2'd0) ? am_reg : ap_reg; mb = cm_reg; end
            ST_SKIP_SQ:  begin ma = (sub_reg == 2'd0) ? cm_reg + 64'd1 : cm_reg;
                               mb = (sub_reg == 2'd0) ? cp_reg : cm_reg; end
            ST_SKIP_FIN: begin ma = am_reg; mb = lcg_reg; end
            default:     begin ma = lcg_reg; mb = PCG_MULT; end
        endcase
    end

    // a clear count bit needs no multiply for the accumulator
    assign mstart = !mbusy_reg && (state_reg == ST_DRAW
                    || (state_reg == ST_SKIP_BIT && n_reg[0])
                    || state_reg == ST_SKIP_SQ || state_reg == ST_SKIP_FIN);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (req.valid && req.ready)
                begin
                    unique case (req.opcode)
                        OP_NEXT32, OP_NEXT64: state_next = ST_DRAW;
                        OP_UNIFORM: state_next = (a_s == b_s) ? ST_OUT : ST_DRAW;
                        OP_SKIP:    state_next = (req.skip_count == 64'd0) ? ST_IDLE : ST_SKIP_BIT;
                        OP_RESEED:  state_next = ST_DRAW;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            ST_DRAW:
                if (mdone)
                begin
                    priority if (op_reg == OP_RESEED)
                        state_next = (phase_reg == 2'd1) ? ST_IDLE : ST_RES_ADD;
                    else if (op_reg == OP_NEXT64 && phase_reg == 2'd0)
                        state_next = ST_DRAW;
                    else if (op_reg == OP_UNIFORM && !full_reg)
                        state_next = ST_MOD;
                    else
                        state_next = ST_OUT;
                end
            ST_RES_ADD:  state_next = ST_DRAW;
            ST_MOD:      if (ddone) state_next = ST_OUT;
            ST_SKIP_BIT: if (!n_reg[0] || (mdone && sub_reg == 2'd1)) state_next = ST_SKIP_SQ;
            ST_SKIP_SQ:
                if (mdone && sub_reg == 2'd1)
                    state_next = (n_reg[63:1] == 63'd0) ? ST_SKIP_FIN : ST_SKIP_BIT;
            ST_SKIP_FIN: if (mdone) state_next = ST_IDLE;
            ST_OUT:      state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            seed_reg  <= '0;
            lcg_reg   <= RESET_STATE;
            inc_reg   <= 64'd1;
            res.valid <= 1'b0;
            mbusy_reg <= 1'b0;
            phase_reg <= '0;
            sub_reg   <= '0;
            op_reg    <= OP_NEXT32;
            mod_go_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mod_go_reg <= 1'b0;
            if (cfg_we)
                seed_reg <= cfg_wdata;
            if (mstart)
                mbusy_reg <= 1'b1;
            else if (mdone)
                mbusy_reg <= 1'b0;
            if (res.valid && res.ready)
                res.valid <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                    if (req.valid && req.ready)
                    begin
                        op_reg    <= opcode_t'(req.opcode);
                        phase_reg <= '0;
                        sub_reg   <= '0;
                        if (req.opcode == OP_RESEED)
                        begin
                            lcg_reg <= '0;
                            inc_reg <= {seed_reg[62:0], 1'b1};
                        end
                    end
                ST_DRAW:
                    if (mdone)
                    begin
                        lcg_reg <= mp + inc_reg;
                        phase_reg <= phase_reg + 2'd1;
                        if (op_reg == OP_UNIFORM && !full_reg)
                            mod_go_reg <= 1'b1;
                    end
                ST_RES_ADD: lcg_reg <= lcg_reg + seed_reg;
                ST_SKIP_BIT:
                    if (!n_reg[0])
                        sub_reg <= '0;
                    else if (mdone)
                        sub_reg <= (sub_reg == 2'd1) ? 2'd0 : 2'd1;
                ST_SKIP_SQ:
                    if (mdone)
                        sub_reg <= (sub_reg == 2'd1) ? 2'd0 : 2'd1;
                ST_SKIP_FIN:
                    if (mdone)
                        lcg_reg <= mp + ap_reg;
                ST_OUT:     res.valid <= 1'b1;
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
                if (req.valid && req.ready)
                begin
                    lo_reg   <= 32'(mn);
                    span_reg <= 32'(mx) - 32'(mn) + 32'd1;
                    full_reg <= (32'(mx) - 32'(mn)) == 32'hFFFF_FFFF;
                    n_reg    <= req.skip_count;
                    cm_reg   <= PCG_MULT;
                    cp_reg   <= inc_reg;
                    am_reg   <= 64'd1;
                    ap_reg   <= '0;
                    res.random_value  <= '0;
                    // equal bounds return the bound; other opcodes leave this field zero
                    res.uniform_value <= (req.opcode == OP_UNIFORM) ? mn : 32'sd0;
                end
            ST_DRAW:
                if (mdone)
                begin
                    r_reg  <= xsh_rr(lcg_reg);
                    hi_reg <= xsh_rr(lcg_reg);
                    if (op_reg == OP_NEXT32)
                        res.random_value <= {32'd0, xsh_rr(lcg_reg)};
                    else if (op_reg == OP_NEXT64 && phase_reg == 2'd1)
                        res.random_value <= {hi_reg, xsh_rr(lcg_reg)};
                    else if (op_reg == OP_UNIFORM)
                        res.uniform_value <= lo_reg + xsh_rr(lcg_reg);
                end
            ST_MOD:
                if (ddone)
                    res.uniform_value <= lo_reg + drem;
            ST_SKIP_BIT:
                if (mdone)
                begin
                    if (sub_reg == 2'd0)
                        am_reg <= mp;
                    else
                        ap_reg <= mp + cp_reg;
                end
            ST_SKIP_SQ:
                if (mdone)
                begin
                    if (sub_reg == 2'd0)
                        cp_reg <= mp;
                    else
                    begin
                        cm_reg <= mp;
                        n_reg  <= n_reg >> 1;
                    end
                end
            default: ;
        endcase
    end
endmodule

// ----- rtl/pcg_mul64.sv -----
// 64x64 low-half multiply, one 32x32 partial product per cycle
module pcg_mul64
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] p
);
    import pcg_pkg::*;
    logic [1:0]  step_reg, step_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] a_reg, b_reg;
    logic [31:0] x, y;
    logic [63:0] prod;

    always_comb
    begin
        unique case (step_reg)
            2'd1:    begin x = a_reg[31:0];  y = b_reg[31:0];  end
            2'd2:    begin x = a_reg[63:32]; y = b_reg[31:0];  end
            default: begin x = a_reg[31:0];  y = b_reg[63:32]; end
        endcase
        prod = 64'(x) * 64'(y);
        acc_next = acc_reg;
        step_next = step_reg;
        if (start)
        begin
            acc_next = '0;
            step_next = 2'd1;
        end
        else if (step_reg != 2'd0)
        begin
            if (step_reg == 2'd1)
                acc_next = prod;
            else
                acc_next = acc_reg + {prod[31:0], 32'd0};
            step_next = (step_reg == 2'd3) ? 2'd0 : step_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else
            step_reg <= step_next;
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
    end

    assign done = (step_reg == 2'd3);
    assign p = acc_next;
endmodule

// ----- rtl/pcg_divmod.sv -----
// restoring remainder, one quotient bit per cycle
module pcg_divmod
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [31:0] rem
);
    import pcg_pkg::*;
    logic [5:0]  cnt_reg;
    logic [31:0] num_reg;
    logic [32:0] rem_reg;
    logic [31:0] den_reg;
    logic [32:0] sh;

    assign sh = {rem_reg[31:0], num_reg[31]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (start)
            cnt_reg <= 6'd32;
        else if (cnt_reg != 6'd0)
            cnt_reg <= cnt_reg - 6'd1;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (cnt_reg != 6'd0)
        begin
            num_reg <= {num_reg[30:0], 1'b0};
            rem_reg <= (sh >= {1'b0, den_reg}) ? sh - {1'b0, den_reg} : sh;
        end
    end

    assign done = (cnt_reg == 6'd1);
    assign rem  = (sh >= {1'b0, den_reg}) ? 32'(sh - {1'b0, den_reg}) : sh[31:0];
endmodule
